// ===== rtl/rsb_pkg.sv =====
// Shared types, register indexes and datapath widths of the rotated sprite blitter.
`default_nettype none

package rsb_pkg;

    localparam int RSB_DISPLAY_W = 128;
    localparam int RSB_DISPLAY_H = 128;
    localparam int RSB_SRC_MAX_W = 128;
    localparam int RSB_SRC_MAX_H = 128;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [31:0] SIN_COS_RST    = 32'h0000_4000;
    localparam logic [31:0] SCALE_PAIR_RST = 32'h0100_0100;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    // datapath widths
    localparam int DIFF_W = 34;  // px*256 - cx*scale
    localparam int X0_W   = 26;  // placement origin
    localparam int PIV_W  = 33;  // pivot times scale, Q.12
    localparam int DX_W   = 40;  // offset from pivot, Q.12
    localparam int PROD_W = 56;  // offset times sin or cos
    localparam int SUM_W  = 57;
    localparam int U1_W   = 31;
    localparam int W_W    = 44;
    localparam int U2_W   = 32;
    localparam int Q_W    = 49;  // times reciprocal scale
    localparam int S_W    = 41;  // source coordinate
    localparam int IDX_W  = 13;  // coordinate index, covers 4096

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLACE_XY    = 3'd0,
        REG_CENTER_XY   = 3'd1,
        REG_PIVOT_XY    = 3'd2,
        REG_SIN_COS     = 3'd3,
        REG_SCALE_PAIR  = 3'd4,
        REG_CROP_WINDOW = 3'd5,
        REG_KEY_COLOR   = 3'd6,
        REG_SOURCE_SIZE = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic        opcode;
        logic [6:0]  coord_x;
        logic [6:0]  coord_y;
        logic [31:0] pixel_color;
    } in_item_t;

    typedef struct packed {
        logic        draw;
        logic [6:0]  out_x;
        logic [6:0]  out_y;
        logic [31:0] out_color;
    } out_item_t;

    // request data that rides along the pipeline
    typedef struct packed {
        logic        opcode;
        logic        ok;      // map: inside window / source; load: address in range
        logic [6:0]  x;
        logic [6:0]  y;
        logic [31:0] color;
    } side_t;

    typedef struct packed {
        logic signed [PIV_W-1:0] xrs;
        logic signed [PIV_W-1:0] yrs;
    } piv_t;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [15:0]        cx;
        logic [15:0]        cy;
        logic signed [15:0] xr;
        logic signed [15:0] yr;
        logic signed [15:0] sn;
        logic signed [15:0] cs;
        logic [15:0]        sc;
        logic [15:0]        rc;
        logic signed [15:0] xs0;
        logic signed [15:0] xw;
        logic signed [15:0] ys0;
        logic signed [15:0] yw;
        logic [31:0]        key;
        logic [15:0]        sw;
        logic [15:0]        sh;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/rsb_front.sv =====
// Front stages: crop test, placement origin and offset from the scaled pivot.
`default_nettype none

module rsb_front import rsb_pkg::*; #(
    parameter int DISPLAY_W = RSB_DISPLAY_W,
    parameter int DISPLAY_H = RSB_DISPLAY_H,
    parameter int SRC_MAX_W = RSB_SRC_MAX_W,
    parameter int SRC_MAX_H = RSB_SRC_MAX_H
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output side_t                  out_side,
    output piv_t                   out_piv,
    output logic signed [DX_W-1:0] out_dx,
    output logic signed [DX_W-1:0] out_dy
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    side_t s1_reg, s2_reg, s3_reg, s4_reg;
    side_t s1_next;
    piv_t  p1_reg, p2_reg, p3_reg, p4_reg;
    piv_t  p1_next;

    logic [31:0] cxsc_reg, cysc_reg, cxsc_next, cysc_next;
    logic signed [DIFF_W-1:0] dfx_reg, dfy_reg, dfx_next, dfy_next;
    logic signed [DIFF_W-1:0] dfx_b, dfy_b;
    logic signed [X0_W-1:0]   x0_reg, y0_reg, x0_next, y0_next;
    logic signed [26:0]       dxa, dya;
    logic signed [DX_W-1:0]   dx_reg, dy_reg, dx_next, dy_next;

    logic signed [16:0] xe, ye, ci, cj;
    logic               crop_ok, load_ok;

    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    // stage 1: window test, center and pivot products
    always_comb begin
        ci = $signed({10'b0, in_item.coord_x});
        cj = $signed({10'b0, in_item.coord_y});
        xe = $signed({cfg.xs0[15], cfg.xs0}) + $signed({cfg.xw[15], cfg.xw});
        ye = $signed({cfg.ys0[15], cfg.ys0}) + $signed({cfg.yw[15], cfg.yw});
        crop_ok = (ci >= $signed({cfg.xs0[15], cfg.xs0})) && (ci < xe)
               && (int'(in_item.coord_x) < DISPLAY_W)
               && (cj >= $signed({cfg.ys0[15], cfg.ys0})) && (cj < ye)
               && (int'(in_item.coord_y) < DISPLAY_H);
        load_ok = (int'(in_item.coord_x) < SRC_MAX_W) && (int'(in_item.coord_y) < SRC_MAX_H);

        s1_next.opcode = in_item.opcode;
        s1_next.ok     = (in_item.opcode == OP_MAP) ? crop_ok : load_ok;
        s1_next.x      = in_item.coord_x;
        s1_next.y      = in_item.coord_y;
        s1_next.color  = in_item.pixel_color;

        cxsc_next   = cfg.cx * cfg.sc;
        cysc_next   = cfg.cy * cfg.sc;
        p1_next.xrs = $signed(cfg.xr) * $signed({1'b0, cfg.sc});
        p1_next.yrs = $signed(cfg.yr) * $signed({1'b0, cfg.sc});
    end

    // stage 2: place*256 - center*scale
    always_comb begin
        dfx_next = $signed({{10{cfg.px[15]}}, cfg.px, 8'b0}) - $signed({2'b0, cxsc_reg});
        dfy_next = $signed({{10{cfg.py[15]}}, cfg.py, 8'b0}) - $signed({2'b0, cysc_reg});
    end

    // stage 3: divide by 256 toward zero
    always_comb begin
        dfx_b   = dfx_reg + $signed({{(DIFF_W-8){1'b0}}, {8{dfx_reg[DIFF_W-1]}}});
        dfy_b   = dfy_reg + $signed({{(DIFF_W-8){1'b0}}, {8{dfy_reg[DIFF_W-1]}}});
        x0_next = dfx_b[DIFF_W-1:8];
        y0_next = dfy_b[DIFF_W-1:8];
    end

    // stage 4: offset from pivot in Q.12
    always_comb begin
        dxa = $signed({20'b0, s3_reg.x}) - $signed({x0_reg[X0_W-1], x0_reg});
        dya = $signed({20'b0, s3_reg.y}) - $signed({y0_reg[X0_W-1], y0_reg});
        dx_next = $signed({dxa[26], dxa, 12'b0})
                - $signed({{(DX_W-PIV_W){p3_reg.xrs[PIV_W-1]}}, p3_reg.xrs});
        dy_next = $signed({dya[26], dya, 12'b0})
                - $signed({{(DX_W-PIV_W){p3_reg.yrs[PIV_W-1]}}, p3_reg.yrs});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_reg   <= s1_next;
            p1_reg   <= p1_next;
            cxsc_reg <= cxsc_next;
            cysc_reg <= cysc_next;
        end
        if (en2) begin
            s2_reg  <= s1_reg;
            p2_reg  <= p1_reg;
            dfx_reg <= dfx_next;
            dfy_reg <= dfy_next;
        end
        if (en3) begin
            s3_reg <= s2_reg;
            p3_reg <= p2_reg;
            x0_reg <= x0_next;
            y0_reg <= y0_next;
        end
        if (en4) begin
            s4_reg <= s3_reg;
            p4_reg <= p3_reg;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_side  = s4_reg;
    assign out_piv   = p4_reg;
    assign out_dx    = dx_reg;
    assign out_dy    = dy_reg;

endmodule

`default_nettype wire

// ===== rtl/rsb_rotate.sv =====
// Rotation stages: products with sin and cos, sums, and the return to pixel units.
`default_nettype none

module rsb_rotate import rsb_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  side_t                  in_side,
    input  piv_t                   in_piv,
    input  logic signed [DX_W-1:0] in_dx,
    input  logic signed [DX_W-1:0] in_dy,
    output logic                   out_valid,
    input  logic                   out_ready,
    output side_t                  out_side,
    output logic signed [U2_W-1:0] out_u,
    output logic signed [U2_W-1:0] out_v
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    side_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    piv_t  p1_reg, p2_reg, p3_reg;

    logic signed [PROD_W-1:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic signed [PROD_W-1:0] pxc_next, pys_next, pyc_next, pxs_next;
    logic signed [SUM_W-1:0]  su_reg, sv_reg, su_next, sv_next, su_b, sv_b;
    logic signed [U1_W-1:0]   u1_reg, v1r_reg, u1_next, v1r_next;
    logic signed [W_W-1:0]    wu_reg, wv_reg, wu_next, wv_next, wu_b, wv_b;
    logic signed [U2_W-1:0]   u2_reg, v2r_reg, u2_next, v2r_next;

    assign en5 = !v5_reg || out_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        pxc_next = $signed(in_dx) * $signed(cfg.cs);
        pys_next = $signed(in_dy) * $signed(cfg.sn);
        pyc_next = $signed(in_dy) * $signed(cfg.cs);
        pxs_next = $signed(in_dx) * $signed(cfg.sn);

        su_next = $signed({pxc_reg[PROD_W-1], pxc_reg}) + $signed({pys_reg[PROD_W-1], pys_reg});
        sv_next = $signed({pyc_reg[PROD_W-1], pyc_reg}) - $signed({pxs_reg[PROD_W-1], pxs_reg});

        // divide by 2^26 toward zero
        su_b     = su_reg + $signed({{(SUM_W-26){1'b0}}, {26{su_reg[SUM_W-1]}}});
        sv_b     = sv_reg + $signed({{(SUM_W-26){1'b0}}, {26{sv_reg[SUM_W-1]}}});
        u1_next  = su_b[SUM_W-1:26];
        v1r_next = sv_b[SUM_W-1:26];

        wu_next = $signed({u1_reg[U1_W-1], u1_reg, 12'b0})
                + $signed({{(W_W-PIV_W){p3_reg.xrs[PIV_W-1]}}, p3_reg.xrs});
        wv_next = $signed({v1r_reg[U1_W-1], v1r_reg, 12'b0})
                + $signed({{(W_W-PIV_W){p3_reg.yrs[PIV_W-1]}}, p3_reg.yrs});

        wu_b     = wu_reg + $signed({{(W_W-12){1'b0}}, {12{wu_reg[W_W-1]}}});
        wv_b     = wv_reg + $signed({{(W_W-12){1'b0}}, {12{wv_reg[W_W-1]}}});
        u2_next  = wu_b[W_W-1:12];
        v2r_next = wv_b[W_W-1:12];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_reg  <= in_side;
            p1_reg  <= in_piv;
            pxc_reg <= pxc_next;
            pys_reg <= pys_next;
            pyc_reg <= pyc_next;
            pxs_reg <= pxs_next;
        end
        if (en2) begin
            s2_reg <= s1_reg;
            p2_reg <= p1_reg;
            su_reg <= su_next;
            sv_reg <= sv_next;
        end
        if (en3) begin
            s3_reg  <= s2_reg;
            p3_reg  <= p2_reg;
            u1_reg  <= u1_next;
            v1r_reg <= v1r_next;
        end
        if (en4) begin
            s4_reg <= s3_reg;
            wu_reg <= wu_next;
            wv_reg <= wv_next;
        end
        if (en5) begin
            s5_reg  <= s4_reg;
            u2_reg  <= u2_next;
            v2r_reg <= v2r_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_side  = s5_reg;
    assign out_u     = u2_reg;
    assign out_v     = v2r_reg;

endmodule

`default_nettype wire

// ===== rtl/rsb_scale.sv =====
// Scale stages: reciprocal multiply, source bounds test and image address.
`default_nettype none

module rsb_scale import rsb_pkg::*; #(
    parameter int SRC_MAX_W = RSB_SRC_MAX_W,
    parameter int SRC_MAX_H = RSB_SRC_MAX_H,
    localparam int DEPTH = SRC_MAX_W * SRC_MAX_H,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  side_t                  in_side,
    input  logic signed [U2_W-1:0] in_u,
    input  logic signed [U2_W-1:0] in_v,
    output logic                   out_valid,
    input  logic                   out_ready,
    output side_t                  out_side,
    output logic [AW-1:0]          out_addr
);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    side_t s1_reg, s2_reg, s3_reg, s3_next;

    logic signed [Q_W-1:0] qu_reg, qv_reg, qu_next, qv_next, qu_b, qv_b;
    logic signed [S_W-1:0] sx_reg, sy_reg, sx_next, sy_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [IDX_W-1:0]      xi, yi;
    logic                  x_in, y_in;

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        qu_next = $signed(in_u) * $signed({1'b0, cfg.rc});
        qv_next = $signed(in_v) * $signed({1'b0, cfg.rc});

        qu_b    = qu_reg + $signed({{(Q_W-8){1'b0}}, {8{qu_reg[Q_W-1]}}});
        qv_b    = qv_reg + $signed({{(Q_W-8){1'b0}}, {8{qv_reg[Q_W-1]}}});
        sx_next = qu_b[Q_W-1:8];
        sy_next = qv_b[Q_W-1:8];

        x_in = !sx_reg[S_W-1]
            && (sx_reg[S_W-2:0] < (S_W-1)'(cfg.sw))
            && (sx_reg[S_W-2:0] < (S_W-1)'(SRC_MAX_W));
        y_in = !sy_reg[S_W-1]
            && (sy_reg[S_W-2:0] < (S_W-1)'(cfg.sh))
            && (sy_reg[S_W-2:0] < (S_W-1)'(SRC_MAX_H));

        s3_next = s2_reg;
        if (s2_reg.opcode == OP_MAP) begin
            xi         = sx_reg[IDX_W-1:0];
            yi         = sy_reg[IDX_W-1:0];
            s3_next.ok = s2_reg.ok && x_in && y_in;
        end else begin
            xi = IDX_W'(s2_reg.x);
            yi = IDX_W'(s2_reg.y);
        end
        addr_next = AW'(32'(yi) * SRC_MAX_W + 32'(xi));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_reg <= in_side;
            qu_reg <= qu_next;
            qv_reg <= qv_next;
        end
        if (en2) begin
            s2_reg <= s1_reg;
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        if (en3) begin
            s3_reg   <= s3_next;
            addr_reg <= addr_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = s3_reg;
    assign out_addr  = addr_reg;

endmodule

`default_nettype wire

// ===== rtl/rsb_fetch.sv =====
// Source image memory, color key test and result register.
`default_nettype none

module rsb_fetch import rsb_pkg::*; #(
    parameter int SRC_MAX_W = RSB_SRC_MAX_W,
    parameter int SRC_MAX_H = RSB_SRC_MAX_H,
    localparam int DEPTH = SRC_MAX_W * SRC_MAX_H,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cfg_t          cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  side_t         in_side,
    input  logic [AW-1:0] in_addr,
    output logic          out_valid,
    input  logic          out_ready,
    output out_item_t     out_item
);

    logic [31:0] mem [DEPTH];

    logic        vb_reg, ov_reg;
    logic        en_b, en_c;
    side_t       sb_reg;
    logic [31:0] rdata_reg;
    out_item_t   out_reg, out_next;

    assign en_c = !ov_reg || out_ready;
    assign en_b = !vb_reg || en_c;
    assign in_ready = en_b;

    // loads write and maps read at the same stage, so request order holds
    always_ff @(posedge aclk) begin
        if (en_b && in_valid) begin
            if (in_side.opcode == OP_LOAD) begin
                if (in_side.ok) mem[in_addr] <= in_side.color;
            end else begin
                rdata_reg <= mem[in_addr];
            end
        end
    end

    always_comb begin
        out_next.draw      = sb_reg.ok && (rdata_reg != cfg.key);
        out_next.out_x     = sb_reg.x;
        out_next.out_y     = sb_reg.y;
        out_next.out_color = out_next.draw ? rdata_reg : 32'h0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (en_b) vb_reg <= in_valid && (in_side.opcode == OP_MAP);
            if (en_c) ov_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b) sb_reg <= in_side;
        if (en_c) out_reg <= out_next;
    end

    assign out_valid = ov_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/rotated_sprite_blit.sv =====
// Top level of the rotate-and-scale sprite blitter with color key.
// Fourteen register stages lie between an accepted map request and its result.
// One request per cycle sustained; a stalled output only halts stages that hold requests.
// Loads write the source image in the memory stage and produce no result.
// Synchronous active-low reset clears valid bits and resets configuration; the image is not cleared.
`default_nettype none

module rotated_sprite_blit import rsb_pkg::*; #(
    parameter int DISPLAY_W = RSB_DISPLAY_W,
    parameter int DISPLAY_H = RSB_DISPLAY_H,
    parameter int SRC_MAX_W = RSB_SRC_MAX_W,
    parameter int SRC_MAX_H = RSB_SRC_MAX_H,
    localparam int DEPTH = SRC_MAX_W * SRC_MAX_H,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    logic [31:0] place_xy_reg, center_xy_reg, pivot_xy_reg, sin_cos_reg;
    logic [31:0] scale_pair_reg, key_color_reg, source_size_reg;
    logic [63:0] crop_window_reg;
    cfg_t        cfg;

    logic                   f_valid, f_ready;
    side_t                  f_side;
    piv_t                   f_piv;
    logic signed [DX_W-1:0] f_dx, f_dy;

    logic                   r_valid, r_ready;
    side_t                  r_side;
    logic signed [U2_W-1:0] r_u, r_v;

    logic          c_valid, c_ready;
    side_t         c_side;
    logic [AW-1:0] c_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            place_xy_reg    <= '0;
            center_xy_reg   <= '0;
            pivot_xy_reg    <= '0;
            sin_cos_reg     <= SIN_COS_RST;
            scale_pair_reg  <= SCALE_PAIR_RST;
            crop_window_reg <= '0;
            key_color_reg   <= '0;
            source_size_reg <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_PLACE_XY:    place_xy_reg    <= cfg_wdata[31:0];
                REG_CENTER_XY:   center_xy_reg   <= cfg_wdata[31:0];
                REG_PIVOT_XY:    pivot_xy_reg    <= cfg_wdata[31:0];
                REG_SIN_COS:     sin_cos_reg     <= cfg_wdata[31:0];
                REG_SCALE_PAIR:  scale_pair_reg  <= cfg_wdata[31:0];
                REG_CROP_WINDOW: crop_window_reg <= cfg_wdata;
                REG_KEY_COLOR:   key_color_reg   <= cfg_wdata[31:0];
                REG_SOURCE_SIZE: source_size_reg <= cfg_wdata[31:0];
            endcase
        end
    end

    always_comb begin
        cfg.px  = place_xy_reg[31:16];
        cfg.py  = place_xy_reg[15:0];
        cfg.cx  = center_xy_reg[31:16];
        cfg.cy  = center_xy_reg[15:0];
        cfg.xr  = pivot_xy_reg[31:16];
        cfg.yr  = pivot_xy_reg[15:0];
        cfg.sn  = sin_cos_reg[31:16];
        cfg.cs  = sin_cos_reg[15:0];
        cfg.sc  = scale_pair_reg[31:16];
        cfg.rc  = scale_pair_reg[15:0];
        cfg.xs0 = crop_window_reg[63:48];
        cfg.xw  = crop_window_reg[47:32];
        cfg.ys0 = crop_window_reg[31:16];
        cfg.yw  = crop_window_reg[15:0];
        cfg.key = key_color_reg;
        cfg.sw  = source_size_reg[31:16];
        cfg.sh  = source_size_reg[15:0];
    end

    rsb_front #(
        .DISPLAY_W (DISPLAY_W),
        .DISPLAY_H (DISPLAY_H),
        .SRC_MAX_W (SRC_MAX_W),
        .SRC_MAX_H (SRC_MAX_H)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_side  (f_side),
        .out_piv   (f_piv),
        .out_dx    (f_dx),
        .out_dy    (f_dy)
    );

    rsb_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_side   (f_side),
        .in_piv    (f_piv),
        .in_dx     (f_dx),
        .in_dy     (f_dy),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_side  (r_side),
        .out_u     (r_u),
        .out_v     (r_v)
    );

    rsb_scale #(
        .SRC_MAX_W (SRC_MAX_W),
        .SRC_MAX_H (SRC_MAX_H)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_side   (r_side),
        .in_u      (r_u),
        .in_v      (r_v),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_side  (c_side),
        .out_addr  (c_addr)
    );

    rsb_fetch #(
        .SRC_MAX_W (SRC_MAX_W),
        .SRC_MAX_H (SRC_MAX_H)
    ) u_fetch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_side   (c_side),
        .in_addr   (c_addr),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_data)
    );

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_empty_output_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request refused while output register is empty");

    a_no_draw_zero_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.draw |-> m_data.out_color == 32'h0)
        else $error("color set on a pixel that is not drawn");

    a_draw_on_display: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.draw |-> (int'(m_data.out_x) < DISPLAY_W)
                                && (int'(m_data.out_y) < DISPLAY_H))
        else $error("drawn pixel outside the display");

endmodule

`default_nettype wire
